### hw/rtl/clock_frame_replacement_assert.svh
// Assertion macros shared by the frame replacement modules.
`ifndef CLOCK_FRAME_REPLACEMENT_ASSERT_SVH
`define CLOCK_FRAME_REPLACEMENT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define CFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock_frame_replacement: assertion failed");
// Next-cycle implication.
`define CFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock_frame_replacement: assertion failed");
`else
`define CFR_ASSERT_IMP(lbl, ante, cons)
`define CFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/cfr_pkg.sv
// Shared constants and controller/datapath interface types for the frame table.
package cfr_pkg;

    // Field widths of the stream items
    localparam int OP_W           = 2;
    localparam int USER_PAGE_W    = 20;
    localparam int OWNER_ID_W     = 8;
    localparam int FRAME_INDEX_W  = 6;
    localparam int FRAME_OUT_W    = 6;
    localparam int VICTIM_PAGE_W  = 20;
    localparam int VICTIM_OWNER_W = 8;
    localparam int S_TDATA_W      = 40;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 40;
    localparam int M_TUSER_W      = 2;

    // Free-frame search looks at this many valid bits per cycle
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_POS_W = 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_TOUCH = 2'd2;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNMAP = 1'b1;

    typedef struct packed {
        logic load;        // take the input item
        logic scan_step;   // test one chunk of valid bits
        logic sweep_step;  // clock hand looks at one frame
        logic capture;     // latch the victim's page and owner
        logic commit;      // update the table, load the result register
    } cfr_cmd_t;

    typedef struct packed {
        logic in_valid;     // input item offered
        logic in_alloc;     // offered item is an allocate
        logic chunk_found;  // current chunk has a free frame
        logic chunk_last;   // current chunk is the last one
        logic sweep_hit;    // frame under the hand has its accessed bit set
        logic out_free;     // result register can take a new item
    } cfr_stat_t;

endpackage

### hw/rtl/cfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfr_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cfr_ctrl.sv
// Sequencing state machine for the frame table: accept, scan, sweep, result.
`include "clock_frame_replacement_assert.svh"
module cfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  cfr_pkg::cfr_stat_t st,
    output cfr_pkg::cfr_cmd_t  cmd,
    output logic               in_ready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SWEEP = 5'b00100,
        ST_VICT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (st.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.in_alloc ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.chunk_found)
                begin
                    state_next = ST_DONE;
                end
                else if (st.chunk_last)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (!st.sweep_hit)
                begin
                    state_next = ST_VICT;   // read of the victim entry is under way
                end
            end
            ST_VICT:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CFR_ASSERT_NXT(a_scan_to_sweep, state_reg == ST_SCAN && !st.chunk_found && st.chunk_last, state_reg == ST_SWEEP)
    `CFR_ASSERT_NXT(a_vict_to_done, state_reg == ST_VICT, state_reg == ST_DONE)
    `CFR_ASSERT_NXT(a_done_holds, state_reg == ST_DONE && !st.out_free, state_reg == ST_DONE)

endmodule

### hw/rtl/cfr_datapath.sv
// Frame table datapath: valid/accessed bits, page RAM, free search, hand, result register.
`include "clock_frame_replacement_assert.svh"
module cfr_datapath #(
    parameter int NUM_FRAMES = 64,
    parameter int PAGE_BITS  = 20,
    parameter int OWNER_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfr_pkg::cfr_cmd_t               cmd,
    output cfr_pkg::cfr_stat_t              st,
    input  logic                            s_axis_tvalid,
    input  logic [cfr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [cfr_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cfr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [cfr_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int FW      = $clog2(NUM_FRAMES);
    localparam int NCHUNK  = (NUM_FRAMES + cfr_pkg::CHUNK_W - 1) / cfr_pkg::CHUNK_W;
    localparam int CW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W   = NCHUNK * cfr_pkg::CHUNK_W;
    localparam int CMPW    = ((FW > cfr_pkg::FRAME_INDEX_W) ? FW : cfr_pkg::FRAME_INDEX_W) + 1;
    localparam int ENTRY_W = PAGE_BITS + OWNER_BITS;

    // input fields
    logic [cfr_pkg::USER_PAGE_W-1:0]   in_page;
    logic [cfr_pkg::OWNER_ID_W-1:0]    in_owner;
    logic [cfr_pkg::FRAME_INDEX_W-1:0] in_idx;

    assign in_page  = s_axis_tdata[cfr_pkg::USER_PAGE_W-1:0];
    assign in_owner = s_axis_tdata[cfr_pkg::USER_PAGE_W +: cfr_pkg::OWNER_ID_W];
    assign in_idx   = s_axis_tdata[cfr_pkg::USER_PAGE_W + cfr_pkg::OWNER_ID_W +:
                                   cfr_pkg::FRAME_INDEX_W];

    // held item
    logic [cfr_pkg::OP_W-1:0]          op_reg;
    logic [PAGE_BITS-1:0]              page_reg;
    logic [OWNER_BITS-1:0]             owner_reg;
    logic [cfr_pkg::FRAME_INDEX_W-1:0] idx_reg;

    // table and search state
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [NUM_FRAMES-1:0] acc_reg, acc_next;
    logic [CW-1:0]         chunk_reg, chunk_next;
    logic [FW-1:0]         frame_reg, frame_next;
    logic [FW-1:0]         hand_reg, hand_next;
    logic                  evict_reg, evict_next;
    logic [PAGE_BITS-1:0]  vpage_reg;
    logic [OWNER_BITS-1:0] vowner_reg;

    // result register
    logic                                m_valid_reg, m_valid_next;
    logic [cfr_pkg::FRAME_OUT_W-1:0]     r_frame_reg;
    logic                                r_evict_reg;
    logic [cfr_pkg::VICTIM_PAGE_W-1:0]   r_vpage_reg;
    logic [cfr_pkg::VICTIM_OWNER_W-1:0]  r_vowner_reg;
    logic                                r_status_reg;

    // free search over one chunk of valid bits per cycle
    logic [PAD_W-1:0]                free_pad;
    logic [cfr_pkg::CHUNK_W-1:0]     chunk_bits;
    logic [cfr_pkg::CHUNK_POS_W-1:0] chunk_pos;
    logic [FW-1:0]                   found_frame;

    assign free_pad   = PAD_W'(~valid_reg);     // padding bits read as not free
    assign chunk_bits = free_pad[chunk_reg * cfr_pkg::CHUNK_W +: cfr_pkg::CHUNK_W];

    always_comb
    begin
        chunk_pos = '0;
        for (int i = cfr_pkg::CHUNK_W - 1; i >= 0; i--)
        begin
            if (chunk_bits[i])
            begin
                chunk_pos = cfr_pkg::CHUNK_POS_W'(i);
            end
        end
    end

    assign found_frame = FW'({chunk_reg, chunk_pos});

    function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] f);
        wrap_inc = (f == FW'(NUM_FRAMES - 1)) ? '0 : f + 1'b1;
    endfunction

    // free / touch target
    logic          idx_in_range;
    logic [FW-1:0] idx_frame;
    logic          idx_mapped;

    assign idx_in_range = CMPW'(idx_reg) < CMPW'(NUM_FRAMES);
    assign idx_frame    = FW'(idx_reg);
    assign idx_mapped   = idx_in_range && valid_reg[idx_frame];

    // page/owner store
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;

    assign ram_we = cmd.commit && (op_reg == cfr_pkg::OP_ALLOC);

    cfr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_FRAMES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (frame_reg),
        .wdata ({page_reg, owner_reg}),
        .raddr (frame_reg),
        .rdata (ram_rdata)
    );

    // status to the controller
    assign st.in_valid    = s_axis_tvalid;
    assign st.in_alloc    = s_axis_tuser == cfr_pkg::OP_ALLOC;
    assign st.chunk_found = |chunk_bits;
    assign st.chunk_last  = chunk_reg == CW'(NCHUNK - 1);
    assign st.sweep_hit   = acc_reg[frame_reg];
    assign st.out_free    = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next   = valid_reg;
        acc_next     = acc_reg;
        chunk_next   = chunk_reg;
        frame_next   = frame_reg;
        hand_next    = hand_reg;
        evict_next   = evict_reg;
        m_valid_next = m_valid_reg;

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            chunk_next = '0;
            evict_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            if (|chunk_bits)
            begin
                frame_next = found_frame;
            end
            else if (chunk_reg == CW'(NCHUNK - 1))
            begin
                frame_next = hand_reg;   // table full: start sweep at the hand
            end
            else
            begin
                chunk_next = chunk_reg + 1'b1;
            end
        end

        if (cmd.sweep_step && acc_reg[frame_reg])
        begin
            acc_next[frame_reg] = 1'b0;   // second chance
            frame_next          = wrap_inc(frame_reg);
        end

        if (cmd.capture)
        begin
            evict_next = 1'b1;
        end

        if (cmd.commit)
        begin
            m_valid_next = 1'b1;
            if (op_reg == cfr_pkg::OP_ALLOC)
            begin
                valid_next[frame_reg] = 1'b1;
                acc_next[frame_reg]   = 1'b0;
                if (evict_reg)
                begin
                    hand_next = wrap_inc(frame_reg);
                end
            end
            else if (idx_mapped && op_reg == cfr_pkg::OP_FREE)
            begin
                valid_next[idx_frame] = 1'b0;
                acc_next[idx_frame]   = 1'b0;
            end
            else if (idx_mapped && op_reg == cfr_pkg::OP_TOUCH)
            begin
                acc_next[idx_frame] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            acc_reg     <= '0;
            chunk_reg   <= '0;
            frame_reg   <= '0;
            hand_reg    <= '0;
            evict_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            acc_reg     <= acc_next;
            chunk_reg   <= chunk_next;
            frame_reg   <= frame_next;
            hand_reg    <= hand_next;
            evict_reg   <= evict_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= s_axis_tuser;
            page_reg  <= PAGE_BITS'(in_page);
            owner_reg <= OWNER_BITS'(in_owner);
            idx_reg   <= in_idx;
        end

        if (cmd.capture)
        begin
            vpage_reg  <= ram_rdata[OWNER_BITS +: PAGE_BITS];
            vowner_reg <= ram_rdata[OWNER_BITS-1:0];
        end

        if (cmd.commit)
        begin
            if (op_reg == cfr_pkg::OP_ALLOC)
            begin
                r_frame_reg  <= cfr_pkg::FRAME_OUT_W'(frame_reg);
                r_evict_reg  <= evict_reg;
                r_vpage_reg  <= evict_reg ? cfr_pkg::VICTIM_PAGE_W'(vpage_reg) : '0;
                r_vowner_reg <= evict_reg ? cfr_pkg::VICTIM_OWNER_W'(vowner_reg) : '0;
                r_status_reg <= cfr_pkg::STATUS_OK;
            end
            else
            begin
                r_frame_reg  <= idx_reg;
                r_evict_reg  <= 1'b0;
                r_vpage_reg  <= '0;
                r_vowner_reg <= '0;
                r_status_reg <= (idx_mapped && (op_reg == cfr_pkg::OP_FREE ||
                                                op_reg == cfr_pkg::OP_TOUCH))
                                ? cfr_pkg::STATUS_OK : cfr_pkg::STATUS_UNMAP;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = cfr_pkg::M_TDATA_W'({r_vowner_reg, r_vpage_reg, r_frame_reg});
    assign m_axis_tuser  = {r_status_reg, r_evict_reg};

    `CFR_ASSERT_IMP(a_sweep_only_when_full, cmd.sweep_step, &valid_reg)
    `CFR_ASSERT_NXT(a_commit_shows_result, cmd.commit, m_valid_reg)
    `CFR_ASSERT_IMP(a_hand_in_range, 1'b1, hand_reg <= FW'(NUM_FRAMES - 1))

endmodule

### hw/rtl/clock_frame_replacement.sv
// Top level of the clock (second-chance) frame replacement table.
// Usage:
//   Requests enter on the s_axis channel, one item per handshake. s_axis_tuser
//   carries the opcode (allocate, free, mark accessed); s_axis_tdata carries
//   the page, owner and frame index. Every request returns exactly one item on
//   m_axis: the frame, an eviction flag with the victim's page and owner, and
//   a status bit that flags an unmapped free/touch or an unused opcode.
// Flow from accept to result:
//   free / touch / unused opcode: straight to the table update
//   allocate with a free frame:   scan up to the chunk holding the lowest
//                                 free frame (8 valid bits tested per cycle)
//   allocate that evicts:         full scan, then the hand sweep over 1 to
//                                 NUM_FRAMES+1 frames, one per cycle
//   The free-frame scan and the hand sweep both run on the single sequencer.
//   One item is in work at a time; s_axis_tready is high while the sequencer
//   is idle, also while a finished result waits.
// Reset: all frames invalid, accessed bits clear, hand at frame zero.
// Stall: a held result sits in the output register; the next item is
//   accepted and worked on, and waits before its table update until
//   m_axis_tready frees the register.
module clock_frame_replacement #(
    parameter int NUM_FRAMES = 64,
    parameter int PAGE_BITS  = 20,
    parameter int OWNER_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [19:0] user_page, [27:20] owner_id, [33:28] frame_index, [39:34] zero
    input  logic [cfr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] op
    input  logic [cfr_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [5:0] frame_out, [25:6] victim_page, [33:26] victim_owner, [39:34] zero
    output logic [cfr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] evicted, [1] status
    output logic [cfr_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    cfr_pkg::cfr_cmd_t  cmd;
    cfr_pkg::cfr_stat_t st;

    // sequencer
    cfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    // table, search, hand and result register
    cfr_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### verif/testbench.sv
// Self-checking testbench for the clock replacement frame table.
module testbench;
    import cfr_pkg::*;

    localparam int NFRAMES = 64;
    // The package names no code for the fourth opcode; it must answer as unmapped.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // Cycles with no handshake on either side before the run is called hung.
    // Worst correct stretch: the long receiver hold-off plus a full sweep.
    localparam int IDLE_LIMIT = 3000;
    // Drain time at the end; it outlasts the longest allocate, a full scan and sweep.
    localparam int TAIL_CYCLES = 120;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [USER_PAGE_W-1:0]   page;
        logic [OWNER_ID_W-1:0]    owner;
        logic [FRAME_INDEX_W-1:0] idx;
        int                       gap;    // idle cycles before this item is offered
        bit                       drain;  // hold until every result is back
    } frame_request_t;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0]    frame;
        logic                      evicted;
        logic [VICTIM_PAGE_W-1:0]  vpage;
        logic [VICTIM_OWNER_W-1:0] vowner;
        logic                      status;
    } frame_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // Testbench's own copy of the frame table.
    bit                       tbl_valid [NFRAMES];
    logic [USER_PAGE_W-1:0]   tbl_page [NFRAMES];
    logic [OWNER_ID_W-1:0]    tbl_owner [NFRAMES];
    bit                       tbl_accessed [NFRAMES];
    int                       tbl_hand = 0;

    frame_request_t request_queue[$];
    frame_result_t  pending_results[$];

    bit s_fire = 1'b0;       // input handshake seen at the last rising edge
    int results_seen = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    // Sender state
    int gap_count = 0;

    // Receiver state
    int  rx_cycles = 0;
    int  rx_stall = 0;
    bit  rx_choppy = 1'b1;
    bit  holdoff_done = 1'b0;

    clock_frame_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    initial
    begin
        foreach (tbl_valid[f])
        begin
            tbl_valid[f] = 1'b0;
            tbl_accessed[f] = 1'b0;
            tbl_page[f] = '0;
            tbl_owner[f] = '0;
        end
    end

    // Applies one request to the table copy and returns the result it yields.
    function automatic frame_result_t frame_table_apply(frame_request_t req);
        frame_result_t r;
        int  f;
        int  steps;
        bit  found;
        r = '0;
        r.frame = req.idx;
        r.status = STATUS_UNMAP;
        if (req.op == OP_ALLOC)
        begin
            r.status = STATUS_OK;
            found = 1'b0;
            // Lowest free frame wins; the hand stays put.
            for (f = 0; f < NFRAMES; f++)
            begin
                if (!found && !tbl_valid[f])
                begin
                    found = 1'b1;
                    r.frame = FRAME_OUT_W'(f);
                end
            end
            if (!found)
            begin
                // Second chance: clear set bits until a clear one turns up.
                f = tbl_hand;
                for (steps = 0; steps < 2 * NFRAMES; steps++)
                begin
                    if (!tbl_accessed[f])
                        break;
                    tbl_accessed[f] = 1'b0;
                    f = (f + 1) % NFRAMES;
                end
                r.frame = FRAME_OUT_W'(f);
                r.evicted = 1'b1;
                r.vpage = tbl_page[f];
                r.vowner = tbl_owner[f];
                tbl_hand = (f + 1) % NFRAMES;
            end
            tbl_valid[r.frame] = 1'b1;
            tbl_page[r.frame] = req.page;
            tbl_owner[r.frame] = req.owner;
            tbl_accessed[r.frame] = 1'b0;
        end
        else if ((req.op == OP_FREE || req.op == OP_TOUCH) && tbl_valid[req.idx])
        begin
            r.status = STATUS_OK;
            if (req.op == OP_FREE)
            begin
                tbl_valid[req.idx] = 1'b0;
                tbl_accessed[req.idx] = 1'b0;
            end
            else
                tbl_accessed[req.idx] = 1'b1;
        end
        return r;
    endfunction

    function automatic int pick_gap(bit choppy);
        int r;
        if (!choppy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_request(logic [OP_W-1:0] op, logic [USER_PAGE_W-1:0] page,
                               logic [OWNER_ID_W-1:0] owner,
                               logic [FRAME_INDEX_W-1:0] idx, int gap, bit drain);
        frame_request_t req;
        req.op = op;
        req.page = page;
        req.owner = owner;
        req.idx = idx;
        req.gap = gap;
        req.drain = drain;
        request_queue.push_back(req);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < MAX_PRINTS)
            $display("result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Sender: offers the head of the request queue, inputs change on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_fire)
        begin
            if (request_queue.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (gap_count < request_queue[0].gap)
            begin
                gap_count++;
                s_axis_tvalid <= 1'b0;
            end
            else if (request_queue[0].drain && pending_results.size() != 0)
                s_axis_tvalid <= 1'b0;
            else
            begin
                s_axis_tdata <= {6'b0, request_queue[0].idx, request_queue[0].owner,
                                 request_queue[0].page};
                s_axis_tuser <= request_queue[0].op;
                s_axis_tvalid <= 1'b1;
                void'(request_queue.pop_front());
                gap_count = 0;
            end
        end
    end

    // Receiver: random back-pressure in choppy and calm spells, plus one long
    // hold-off so the result register fills and the input side backs up.
    always @(negedge clk)
    begin
        rx_cycles++;
        if (rx_cycles % 400 == 0)
            rx_choppy = 1'($urandom_range(0, 1));
        if (!holdoff_done && results_seen >= 120)
        begin
            rx_stall = 300;
            holdoff_done = 1'b1;
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_choppy && $urandom_range(0, 99) < 30)
        begin
            rx_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(9, 39);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: predicts on each accepted request, checks each accepted result.
    always @(posedge clk)
    begin
        frame_request_t req;
        frame_result_t  want;
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            req.op = s_axis_tuser[OP_W-1:0];
            req.page = s_axis_tdata[19:0];
            req.owner = s_axis_tdata[27:20];
            req.idx = s_axis_tdata[33:28];
            req.gap = 0;
            req.drain = 1'b0;
            pending_results.push_back(frame_table_apply(req));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, frame", m_axis_tdata[5:0], 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[5:0] !== want.frame)
                    report_mismatch("frame_out", m_axis_tdata[5:0], want.frame);
                if (m_axis_tuser[0] !== want.evicted)
                    report_mismatch("evicted", m_axis_tuser[0], want.evicted);
                if (m_axis_tdata[25:6] !== want.vpage)
                    report_mismatch("victim_page", m_axis_tdata[25:6], want.vpage);
                if (m_axis_tdata[33:26] !== want.vowner)
                    report_mismatch("victim_owner", m_axis_tdata[33:26], want.vowner);
                if (m_axis_tuser[1] !== want.status)
                    report_mismatch("status", m_axis_tuser[1], want.status);
            end
            results_seen++;
        end
    end

    // Watchdog: too long without any handshake means the block is hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int  n;
        int  k;
        int  start;
        int  pct;
        int  next_seg;
        int  next_drain;
        bit  choppy;
        bit  full_sweep_done;
        bit  drain;

        // Directed: unmapped free/touch, the unused opcode, field extremes,
        // refill of a freed frame, fresh mapping starting with a clear bit.
        add_request(OP_TOUCH,  20'h00000, 8'h00, 6'd0,  0, 1'b0);
        add_request(OP_FREE,   20'h00000, 8'h00, 6'd63, 0, 1'b0);
        add_request(OP_UNUSED, 20'h12345, 8'h3C, 6'd21, 0, 1'b0);
        add_request(OP_ALLOC,  20'hFFFFF, 8'hFF, 6'd63, 0, 1'b0);
        add_request(OP_ALLOC,  20'h00000, 8'h00, 6'd0,  2, 1'b0);
        add_request(OP_ALLOC,  20'h5A5A5, 8'h5A, 6'd42, 0, 1'b0);
        add_request(OP_TOUCH,  20'hFFFFF, 8'hFF, 6'd0,  0, 1'b0);
        add_request(OP_TOUCH,  20'h00000, 8'h00, 6'd1,  1, 1'b0);
        add_request(OP_FREE,   20'h00000, 8'h00, 6'd1,  0, 1'b0);
        add_request(OP_TOUCH,  20'h00000, 8'h00, 6'd1,  0, 1'b0);
        add_request(OP_FREE,   20'h00000, 8'h00, 6'd1,  5, 1'b0);
        add_request(OP_ALLOC,  20'hA5A5A, 8'hA5, 6'd21, 0, 1'b0);
        add_request(OP_UNUSED, 20'hFFFFF, 8'hFF, 6'd63, 0, 1'b0);
        add_request(OP_FREE,   20'h00000, 8'h00, 6'd0,  0, 1'b0);
        add_request(OP_ALLOC,  20'h00001, 8'h01, 6'd0,  0, 1'b0);
        add_request(OP_TOUCH,  20'h00000, 8'h00, 6'd63, 0, 1'b0);
        add_request(OP_TOUCH,  20'h00000, 8'h00, 6'd2,  0, 1'b0);

        // Random: allocations dominate so the table fills and evictions follow.
        // Now and then every frame is touched before an allocate, which makes
        // the hand go all the way round.
        n = 0;
        next_seg = 0;
        next_drain = 150;
        choppy = 1'b0;
        full_sweep_done = 1'b0;
        while (n < RANDOM_ITEMS)
        begin
            if (n >= next_seg)
            begin
                choppy = $urandom_range(0, 3) != 0;
                next_seg = n + 100;
            end
            drain = 1'b0;
            if (n >= next_drain)
            begin
                drain = 1'b1;
                next_drain = n + 150;
            end
            if ($urandom_range(0, 199) == 0 || (n >= 300 && !full_sweep_done))
            begin
                full_sweep_done = 1'b1;
                start = $urandom_range(0, NFRAMES - 1);
                for (k = 0; k < NFRAMES; k++)
                    add_request(OP_TOUCH, USER_PAGE_W'($urandom), OWNER_ID_W'($urandom),
                                FRAME_INDEX_W'((start + k) % NFRAMES),
                                pick_gap(choppy), drain && k == 0);
                add_request(OP_ALLOC, USER_PAGE_W'($urandom), OWNER_ID_W'($urandom),
                            FRAME_INDEX_W'($urandom), pick_gap(choppy), 1'b0);
                n += NFRAMES + 1;
            end
            else
            begin
                pct = $urandom_range(0, 99);
                add_request(pct < 48 ? OP_ALLOC : pct < 73 ? OP_TOUCH :
                            pct < 90 ? OP_FREE : OP_UNUSED,
                            USER_PAGE_W'($urandom), OWNER_ID_W'($urandom),
                            FRAME_INDEX_W'($urandom_range(0, NFRAMES - 1)),
                            pick_gap(choppy), drain);
                n++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (request_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
